FILE: rtl/ddo_pkg.sv
// Shared types and constants for the differential-drive odometry block.
// Used by differential_drive_odometry; no dependencies.
package ddo_pkg;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_GO, S_RD_WAIT, S_RS_GO, S_DIV, S_WD_GO, S_WD_WAIT, S_HEAD,
    S_CINIT, S_CORD, S_XM_GO, S_XM_WAIT, S_YM_GO, S_YM_WAIT, S_DONE
  } state_t;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_TRACK  = 2'd1;
  localparam logic [1:0] REG_STEP   = 2'd2;

  localparam logic [19:0] RADIUS_RST = 20'd6554;
  localparam logic [19:0] TRACK_RST  = 20'd36045;
  localparam logic [23:0] STEP_RST   = 24'd167772;

  localparam logic signed [35:0] PI_Q29       = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q29   = 36'sd3373259426;
  localparam logic signed [35:0] THREE_PI_Q29 = 36'sd5059889139;
  localparam logic signed [33:0] HALF_PI_Q29  = 34'sd843314856;
  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic [33:0]        STEP_LIMIT   = 34'h200000000;

  localparam logic [5:0] DIV_LAST    = 6'd60;
  localparam logic [4:0] CORDIC_LAST = 5'd29;

  function automatic logic [28:0] atan_q29(input logic [4:0] i);
    logic [28:0] v;
    unique case (i)
      5'd0:  v = 29'd421657428;
      5'd1:  v = 29'd248918915;
      5'd2:  v = 29'd131521918;
      5'd3:  v = 29'd66762579;
      5'd4:  v = 29'd33510843;
      5'd5:  v = 29'd16771758;
      5'd6:  v = 29'd8387925;
      5'd7:  v = 29'd4194219;
      5'd8:  v = 29'd2097141;
      5'd9:  v = 29'd1048575;
      5'd30, 5'd31: v = 29'd0;
      default: v = 29'd1 << (5'd29 - i);
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/ddo_mul.sv
// Shared 64x32 unsigned multiplier: one 32x32 multiplier used twice per item.
// Depends on nothing.
module ddo_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [95:0] prod
);

  logic [1:0]  ph;
  logic [63:0] a_r;
  logic [31:0] b_r;
  logic [31:0] mop;
  logic [63:0] pm;
  logic [63:0] plo;
  logic [63:0] phi;

  assign mop = (ph == 2'd1) ? a_r[31:0] : a_r[63:32];
  assign pm  = 64'(mop) * 64'(b_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= 2'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (ph)
        2'd0: if (start) ph <= 2'd1;
        2'd1: ph <= 2'd2;
        2'd2: ph <= 2'd3;
        2'd3: begin
          ph   <= 2'd0;
          done <= 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ph == 2'd0 && start) begin
      a_r <= a;
      b_r <= b;
    end
    if (ph == 2'd1) plo <= pm;
    if (ph == 2'd2) phi <= pm;
    if (ph == 2'd3) prod <= {32'd0, plo} + {phi, 32'd0};
  end

endmodule

FILE: rtl/differential_drive_odometry.sv
// Differential-drive odometry: integrates wheel rates into x, y and heading.
// Takes a new item only when idle; a plain integrating item runs the
// 61-step restoring divider for the turn rate and the 30-step CORDIC
// for sine and cosine, with products from the shared ddo_mul.
// The result is held in an output register.
// Depends on ddo_pkg and ddo_mul.
module differential_drive_odometry (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] left_rate,
  input  logic signed [23:0] right_rate,
  input  logic               clear_pose,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] x_out,
  output logic signed [31:0] y_out,
  output logic signed [31:0] heading_out
);

  ddo_pkg::state_t state, state_next;

  logic [19:0] wheel_radius;
  logic [19:0] track_width;
  logic [23:0] time_step;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [31:0] pose_heading;

  logic [24:0] dmag, smag;
  logic        dpos, vneg;
  logic [60:0] div_n;
  logic [19:0] rem;
  logic [5:0]  cnt;
  logic [44:0] rs_prod;
  logic [44:0] vdt;
  logic [32:0] dstep;
  logic signed [33:0] cx, cy, cz;
  logic        cneg;
  logic [4:0]  ci;
  logic        tneg;

  logic        accept;
  logic signed [24:0] diff_in, sum_in;
  logic        mul_start, mul_done;
  logic [63:0] mul_a;
  logic [31:0] mul_b;
  logic [95:0] mul_prod;
  logic [19:0] trk;
  logic [20:0] rem_sh;
  logic        q_bit;
  logic [72:0] dfull;
  logic signed [35:0] hs, hc, hf;
  logic signed [33:0] z0;
  logic signed [33:0] dx, dy, atan_s;
  logic signed [33:0] trig;
  logic [33:0] tmag;
  logic [52:0] m53;
  logic [33:0] mcl;
  logic signed [35:0] p36, n36;
  logic signed [31:0] adv;
  logic        load_out;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ddo_pkg::S_IDLE);
  assign load_out = !out_valid || !out_stall;

  assign diff_in = 25'(right_rate) - 25'(left_rate);
  assign sum_in  = 25'(right_rate) + 25'(left_rate);

  ddo_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_comb begin
    mul_start = 1'b0;
    mul_a     = 64'd0;
    mul_b     = 32'd0;
    unique case (state)
      ddo_pkg::S_RD_GO: begin
        mul_start = 1'b1;
        mul_a = {44'd0, wheel_radius};
        mul_b = {7'd0, dmag};
      end
      ddo_pkg::S_RS_GO: begin
        mul_start = 1'b1;
        mul_a = {44'd0, wheel_radius};
        mul_b = {7'd0, smag};
      end
      ddo_pkg::S_WD_GO: begin
        mul_start = 1'b1;
        mul_a = {3'd0, div_n};
        mul_b = {8'd0, time_step};
      end
      ddo_pkg::S_HEAD: begin
        mul_start = 1'b1;
        mul_a = {19'd0, rs_prod};
        mul_b = {8'd0, time_step};
      end
      ddo_pkg::S_XM_GO, ddo_pkg::S_YM_GO: begin
        mul_start = 1'b1;
        mul_a = {19'd0, vdt};
        mul_b = tmag[31:0];
      end
      default: ;
    endcase
  end

  // divider step
  assign trk    = (track_width == 20'd0) ? 20'd1 : track_width;
  assign rem_sh = {rem, div_n[60]};
  assign q_bit  = (rem_sh >= {1'b0, trk});

  // heading update
  assign dfull = mul_prod[95:23];
  always_comb begin
    hs = dpos ? (36'(pose_heading) - $signed({3'd0, dstep}))
              : (36'(pose_heading) + $signed({3'd0, dstep}));
    if (hs > ddo_pkg::THREE_PI_Q29) hc = ddo_pkg::THREE_PI_Q29;
    else if (hs < -ddo_pkg::THREE_PI_Q29) hc = -ddo_pkg::THREE_PI_Q29;
    else hc = hs;
    if (hc > ddo_pkg::PI_Q29) hf = hc - ddo_pkg::TWO_PI_Q29;
    else if (hc < -ddo_pkg::PI_Q29) hf = hc + ddo_pkg::TWO_PI_Q29;
    else hf = hc;
  end

  assign z0     = 34'(pose_heading);
  assign dx     = cy >>> ci;
  assign dy     = cx >>> ci;
  assign atan_s = $signed({5'd0, ddo_pkg::atan_q29(ci)});

  // trig select and position advance
  always_comb begin
    trig = (state == ddo_pkg::S_XM_GO) ? (cneg ? -cx : cx) : (cneg ? -cy : cy);
    tmag = trig[33] ? 34'(-trig) : 34'(trig);
    m53  = mul_prod[95:43];
    mcl  = (m53 > 53'(ddo_pkg::STEP_LIMIT)) ? ddo_pkg::STEP_LIMIT : m53[33:0];
    p36  = (state == ddo_pkg::S_XM_WAIT) ? 36'(pose_x) : 36'(pose_y);
    n36  = (vneg ^ tneg) ? (p36 - $signed({2'd0, mcl})) : (p36 + $signed({2'd0, mcl}));
    if (n36 > 36'sd2147483647) adv = 32'sh7fffffff;
    else if (n36 < -36'sd2147483648) adv = 32'sh80000000;
    else adv = n36[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ddo_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ddo_pkg::S_IDLE: begin
        if (accept) state_next = clear_pose ? ddo_pkg::S_DONE : ddo_pkg::S_RD_GO;
      end
      ddo_pkg::S_RD_GO:   state_next = ddo_pkg::S_RD_WAIT;
      ddo_pkg::S_RD_WAIT: if (mul_done) state_next = ddo_pkg::S_RS_GO;
      ddo_pkg::S_RS_GO:   state_next = ddo_pkg::S_DIV;
      ddo_pkg::S_DIV:     if (cnt == ddo_pkg::DIV_LAST) state_next = ddo_pkg::S_WD_GO;
      ddo_pkg::S_WD_GO:   state_next = ddo_pkg::S_WD_WAIT;
      ddo_pkg::S_WD_WAIT: if (mul_done) state_next = ddo_pkg::S_HEAD;
      ddo_pkg::S_HEAD:    state_next = ddo_pkg::S_CINIT;
      ddo_pkg::S_CINIT:   state_next = ddo_pkg::S_CORD;
      ddo_pkg::S_CORD:    if (ci == ddo_pkg::CORDIC_LAST) state_next = ddo_pkg::S_XM_GO;
      ddo_pkg::S_XM_GO:   state_next = ddo_pkg::S_XM_WAIT;
      ddo_pkg::S_XM_WAIT: if (mul_done) state_next = ddo_pkg::S_YM_GO;
      ddo_pkg::S_YM_GO:   state_next = ddo_pkg::S_YM_WAIT;
      ddo_pkg::S_YM_WAIT: if (mul_done) state_next = ddo_pkg::S_DONE;
      ddo_pkg::S_DONE:    if (load_out) state_next = ddo_pkg::S_IDLE;
      default:            state_next = ddo_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_radius <= ddo_pkg::RADIUS_RST;
      track_width  <= ddo_pkg::TRACK_RST;
      time_step    <= ddo_pkg::STEP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ddo_pkg::REG_RADIUS: wheel_radius <= cfg_data[19:0];
        ddo_pkg::REG_TRACK:  track_width  <= cfg_data[19:0];
        ddo_pkg::REG_STEP:   time_step    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (accept && clear_pose) begin
        pose_x       <= '0;
        pose_y       <= '0;
        pose_heading <= '0;
      end
      if (state == ddo_pkg::S_HEAD) pose_heading <= hf[31:0];
      if (state == ddo_pkg::S_XM_WAIT && mul_done) pose_x <= adv;
      if (state == ddo_pkg::S_YM_WAIT && mul_done) pose_y <= adv;
      if (state == ddo_pkg::S_DONE && load_out) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dmag <= diff_in[24] ? 25'(-diff_in) : 25'(diff_in);
      smag <= sum_in[24] ? 25'(-sum_in) : 25'(sum_in);
      dpos <= !diff_in[24] && (diff_in != 25'sd0);
      vneg <= !sum_in[24] && (sum_in != 25'sd0);
    end
    unique case (state)
      ddo_pkg::S_RD_WAIT: begin
        if (mul_done) begin
          div_n <= {mul_prod[44:0], 16'd0};
          rem   <= '0;
          cnt   <= '0;
        end
      end
      ddo_pkg::S_DIV: begin
        rem   <= q_bit ? 20'(rem_sh - {1'b0, trk}) : rem_sh[19:0];
        div_n <= {div_n[59:0], q_bit};
        cnt   <= cnt + 6'd1;
        if (mul_done) rs_prod <= mul_prod[44:0];
      end
      ddo_pkg::S_WD_WAIT: begin
        if (mul_done) begin
          dstep <= (dfull > 73'(ddo_pkg::THREE_PI_Q29)) ?
                   ddo_pkg::THREE_PI_Q29[32:0] : dfull[32:0];
        end
      end
      ddo_pkg::S_CINIT: begin
        cx <= ddo_pkg::CORDIC_GAIN;
        cy <= '0;
        ci <= '0;
        if (z0 > ddo_pkg::HALF_PI_Q29) begin
          cz   <= z0 - 34'(ddo_pkg::PI_Q29);
          cneg <= 1'b1;
        end else if (z0 < -ddo_pkg::HALF_PI_Q29) begin
          cz   <= z0 + 34'(ddo_pkg::PI_Q29);
          cneg <= 1'b1;
        end else begin
          cz   <= z0;
          cneg <= 1'b0;
        end
      end
      ddo_pkg::S_CORD: begin
        if (!cz[33]) begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - atan_s;
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + atan_s;
        end
        ci <= ci + 5'd1;
        if (mul_done) vdt <= mul_prod[68:24];
      end
      ddo_pkg::S_XM_GO, ddo_pkg::S_YM_GO: tneg <= trig[33];
      default: ;
    endcase
    if (state == ddo_pkg::S_DONE && load_out) begin
      x_out       <= pose_x;
      y_out       <= pose_y;
      heading_out <= pose_heading;
    end
  end

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    (pose_heading <= 32'sd1686629713) && (pose_heading >= -32'sd1686629713))
    else $error("heading left [-pi,pi]");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    accept && clear_pose |=> (pose_x == 32'sd0) && (pose_y == 32'sd0) &&
    (pose_heading == 32'sd0))
    else $error("clear item did not zero the pose");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ddo_pkg::S_DONE))
    else $error("result raised outside the finish step");

  a_mul_expected: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ddo_pkg::S_RD_WAIT) || (state == ddo_pkg::S_DIV) ||
    (state == ddo_pkg::S_WD_WAIT) || (state == ddo_pkg::S_CORD) ||
    (state == ddo_pkg::S_XM_WAIT) || (state == ddo_pkg::S_YM_WAIT))
    else $error("product finished in an unexpected step");

endmodule
